>>> rtl/lcw_pkg.sv
package lcw_pkg;

   localparam int CFG_W    = 10;
   localparam int CSR_IDX_W = 2;
   localparam int COLOR_W  = 8;
   localparam int PLEN_W   = 9;
   localparam int PSTART_W = 8;
   localparam int WIN_SPAN_W = 11;

   localparam logic [CSR_IDX_W-1:0] IDX_MIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_MIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_MAX_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_MAX_Y = 2'd3;

   localparam logic [CFG_W-1:0] RST_MIN_X = 10'd0;
   localparam logic [CFG_W-1:0] RST_MIN_Y = 10'd0;
   localparam logic [CFG_W-1:0] RST_MAX_X = 10'd319;
   localparam logic [CFG_W-1:0] RST_MAX_Y = 10'd199;

   typedef struct packed {
      logic valid;
      logic ok;
      logic swap;
   } lcw_flags_type;

endpackage

>>> rtl/line_clip_to_window_top.sv
// Line segment clipper.
// req_* carries one segment command per item (valid/ready); rsp_* returns one
// clipped result per item, in order (valid/ready). The csr_* port writes the
// four window registers; write them only while no item is in flight.
// An item passes an x pass and then a y pass, each an order stage, a compare
// stage, a multiply stage, a restoring divider of EW stages (one quotient bit
// per stage, EW = max(COORD_BITS, 11) + 1) and an apply stage, then the
// output register. Throughput is one item per cycle unless the pipeline is
// frozen by a held result; the two quotients of a pass run in parallel
// dividers.
// When rsp_ready is low with a result held, the whole pipeline freezes and
// req_ready drops; nothing is lost or repeated. Otherwise req_ready is high,
// also while a result waits in the pipeline.
// Synchronous reset empties the pipeline and loads the window to
// columns 0..319, rows 0..199.
module line_clip_to_window_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lcw_pkg::CFG_W-1:0]       csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [COORD_BITS-1:0]    req_start_x,
   input  logic signed [COORD_BITS-1:0]    req_start_y,
   input  logic signed [COORD_BITS-1:0]    req_end_x,
   input  logic signed [COORD_BITS-1:0]    req_end_y,
   input  logic [lcw_pkg::COLOR_W-1:0]     req_pen_color,
   input  logic                            req_use_pattern,
   input  logic [lcw_pkg::PLEN_W-1:0]      req_pattern_length,
   input  logic [lcw_pkg::PSTART_W-1:0]    req_pattern_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_visible,
   output logic signed [COORD_BITS-1:0]    rsp_clip_x0,
   output logic signed [COORD_BITS-1:0]    rsp_clip_y0,
   output logic signed [COORD_BITS-1:0]    rsp_clip_x1,
   output logic signed [COORD_BITS-1:0]    rsp_clip_y1,
   output logic [lcw_pkg::COLOR_W-1:0]     rsp_out_color,
   output logic                            rsp_out_use_pattern,
   output logic [lcw_pkg::PSTART_W-1:0]    rsp_out_pattern_start
);
   import lcw_pkg::*;

   localparam int EW     = (COORD_BITS > WIN_SPAN_W ? COORD_BITS : WIN_SPAN_W) + 1;
   localparam int XSIDE_W = COLOR_W + 1 + PLEN_W + PSTART_W;
   localparam int YSIDE_W = COLOR_W + 1 + PSTART_W;

   logic [CFG_W-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= RST_MIN_X;
         min_y_ff <= RST_MIN_Y;
         max_x_ff <= RST_MAX_X;
         max_y_ff <= RST_MAX_Y;
      end else if (csr_wr_en) begin
         case (csr_index)
            IDX_MIN_X: min_x_ff <= csr_wr_data;
            IDX_MIN_Y: min_y_ff <= csr_wr_data;
            IDX_MAX_X: max_x_ff <= csr_wr_data;
            IDX_MAX_Y: max_y_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   lcw_flags_type        xin_flags, xout_flags, yin_flags, yout_flags;
   logic signed [EW-1:0] sx0, sy0, sx1, sy1;
   logic signed [EW-1:0] xa0, xb0, xa1, xb1;
   logic signed [EW-1:0] ya0, yb0, ya1, yb1;
   logic [XSIDE_W-1:0]   xside_in, xside_out;
   logic [YSIDE_W-1:0]   yside_in, yside_out;

   assign sx0 = $signed({{(EW-COORD_BITS){req_start_x[COORD_BITS-1]}}, req_start_x});
   assign sy0 = $signed({{(EW-COORD_BITS){req_start_y[COORD_BITS-1]}}, req_start_y});
   assign sx1 = $signed({{(EW-COORD_BITS){req_end_x[COORD_BITS-1]}}, req_end_x});
   assign sy1 = $signed({{(EW-COORD_BITS){req_end_y[COORD_BITS-1]}}, req_end_y});

   assign xin_flags.valid = req_valid;
   assign xin_flags.ok    = 1'b1;
   assign xin_flags.swap  = 1'b0;
   assign xside_in = {req_pen_color, req_use_pattern, req_pattern_length, req_pattern_start};

   lcw_pass #(.EW(EW), .SIDE_W(XSIDE_W)) u_pass_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_flags  (xin_flags),
      .in_a0     (sx0),
      .in_b0     (sy0),
      .in_a1     (sx1),
      .in_b1     (sy1),
      .lo_a      (min_x_ff),
      .hi_a      (max_x_ff),
      .lo_b      (min_y_ff),
      .hi_b      (max_y_ff),
      .in_side   (xside_in),
      .out_flags (xout_flags),
      .out_a0    (xa0),
      .out_b0    (xb0),
      .out_a1    (xa1),
      .out_b1    (xb1),
      .out_side  (xside_out)
   );

   // mirror the dash start when the x pass swapped the endpoints
   logic [COLOR_W-1:0]  xcolor;
   logic                xusepat;
   logic [PLEN_W-1:0]   xplen, mirror;
   logic [PSTART_W-1:0] xpos, pos_m;

   assign {xcolor, xusepat, xplen, xpos} = xside_out;
   assign mirror = xplen - PLEN_W'(1) - {1'b0, xpos};
   assign pos_m  = xout_flags.swap ? mirror[PSTART_W-1:0] : xpos;

   assign yin_flags = xout_flags;
   assign yside_in  = {xcolor, xusepat, pos_m};

   lcw_pass #(.EW(EW), .SIDE_W(YSIDE_W)) u_pass_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_flags  (yin_flags),
      .in_a0     (xb0),
      .in_b0     (xa0),
      .in_a1     (xb1),
      .in_b1     (xa1),
      .lo_a      (min_y_ff),
      .hi_a      (max_y_ff),
      .lo_b      (min_x_ff),
      .hi_b      (max_x_ff),
      .in_side   (yside_in),
      .out_flags (yout_flags),
      .out_a0    (ya0),
      .out_b0    (yb0),
      .out_a1    (ya1),
      .out_b1    (yb1),
      .out_side  (yside_out)
   );

   logic                  vis_ff;
   logic [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [YSIDE_W-1:0]    side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= yout_flags.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff  <= yout_flags.ok;
         x0_ff   <= yout_flags.ok ? yb0[COORD_BITS-1:0] : '0;
         y0_ff   <= yout_flags.ok ? ya0[COORD_BITS-1:0] : '0;
         x1_ff   <= yout_flags.ok ? yb1[COORD_BITS-1:0] : '0;
         y1_ff   <= yout_flags.ok ? ya1[COORD_BITS-1:0] : '0;
         side_ff <= yout_flags.ok ? yside_out : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = vis_ff;
   assign rsp_clip_x0 = $signed(x0_ff);
   assign rsp_clip_y0 = $signed(y0_ff);
   assign rsp_clip_x1 = $signed(x1_ff);
   assign rsp_clip_y1 = $signed(y1_ff);
   assign {rsp_out_color, rsp_out_use_pattern, rsp_out_pattern_start} = side_ff;

endmodule

>>> rtl/lcw_div.sv
module lcw_div #(
   parameter int DW = 13,
   parameter int QW = 13,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [DW+QW-1:0] in_num,
   input  logic [DW-1:0]    in_den,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [QW-1:0]    out_quo,
   output logic [SW-1:0]    out_side
);

   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic          vld_ff  [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW-1:0] rem_p;
      logic [QW-1:0] low_p;
      logic [DW-1:0] den_p;
      logic [SW-1:0] side_p;
      logic          vld_p;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (i == 0) begin : g_first
         assign rem_p  = in_num[DW+QW-1:QW];
         assign low_p  = in_num[QW-1:0];
         assign den_p  = in_den;
         assign side_p = in_side;
         assign vld_p  = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[i-1];
         assign low_p  = low_ff[i-1];
         assign den_p  = den_ff[i-1];
         assign side_p = side_ff[i-1];
         assign vld_p  = vld_ff[i-1];
      end

      assign trial = {rem_p, low_p[QW-1]};
      assign diff  = trial - {1'b0, den_p};
      assign ge    = (trial >= {1'b0, den_p});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_ff[i]  <= {low_p[QW-2:0], ge};
            den_ff[i]  <= den_p;
            side_ff[i] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = low_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

>>> rtl/lcw_pass.sv
module lcw_pass #(
   parameter int EW = 13,
   parameter int SIDE_W = 26
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  lcw_pkg::lcw_flags_type       in_flags,
   input  logic signed [EW-1:0]         in_a0,
   input  logic signed [EW-1:0]         in_b0,
   input  logic signed [EW-1:0]         in_a1,
   input  logic signed [EW-1:0]         in_b1,
   input  logic [lcw_pkg::CFG_W-1:0]    lo_a,
   input  logic [lcw_pkg::CFG_W-1:0]    hi_a,
   input  logic [lcw_pkg::CFG_W-1:0]    lo_b,
   input  logic [lcw_pkg::CFG_W-1:0]    hi_b,
   input  logic [SIDE_W-1:0]            in_side,
   output lcw_pkg::lcw_flags_type       out_flags,
   output logic signed [EW-1:0]         out_a0,
   output logic signed [EW-1:0]         out_b0,
   output logic signed [EW-1:0]         out_a1,
   output logic signed [EW-1:0]         out_b1,
   output logic [SIDE_W-1:0]            out_side
);
   import lcw_pkg::*;

   localparam int NW    = 2 * EW;
   localparam int CTX_W = 5 + 4 * EW + SIDE_W;

   // order stage
   logic                 va_ff, oka_ff, swa_ff, verta_ff;
   logic signed [EW-1:0] a0a_ff, b0a_ff, a1a_ff, b1a_ff;
   logic [SIDE_W-1:0]    sidea_ff;
   logic                 swap_in, vert_in;

   assign vert_in = (in_a0 == in_a1);
   assign swap_in = vert_in ? (in_b1 < in_b0) : (in_a1 < in_a0);

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_flags.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         oka_ff   <= in_flags.ok;
         swa_ff   <= swap_in;
         verta_ff <= vert_in;
         a0a_ff   <= swap_in ? in_a1 : in_a0;
         b0a_ff   <= swap_in ? in_b1 : in_b0;
         a1a_ff   <= swap_in ? in_a0 : in_a1;
         b1a_ff   <= swap_in ? in_b0 : in_b1;
         sidea_ff <= in_side;
      end
   end

   // window compare and delta stage
   logic signed [EW-1:0] lo_ae, hi_ae, lo_be, hi_be;
   logic signed [EW-1:0] a0c, a1c, b0c, b1c, db, na1, na2, da;
   logic                 c0, c1, okv, oknv;

   assign lo_ae = $signed({{(EW-CFG_W){1'b0}}, lo_a});
   assign hi_ae = $signed({{(EW-CFG_W){1'b0}}, hi_a});
   assign lo_be = $signed({{(EW-CFG_W){1'b0}}, lo_b});
   assign hi_be = $signed({{(EW-CFG_W){1'b0}}, hi_b});

   assign c0   = (a0a_ff < lo_ae);
   assign c1   = (a1a_ff > hi_ae);
   assign a0c  = c0 ? lo_ae : a0a_ff;
   assign a1c  = c1 ? hi_ae : a1a_ff;
   assign b0c  = (b0a_ff < lo_be) ? lo_be : b0a_ff;
   assign b1c  = (b1a_ff > hi_be) ? hi_be : b1a_ff;
   assign db   = b1a_ff - b0a_ff;
   assign na1  = lo_ae - a0a_ff;
   assign na2  = hi_ae - a0c;
   assign da   = a1a_ff - a0a_ff;
   assign okv  = (a0a_ff >= lo_ae) && (a0a_ff <= hi_ae)
                 && !((b1a_ff < lo_be) || (b0a_ff > hi_be));
   assign oknv = (a0c <= a1a_ff) && (a0c <= hi_ae);

   logic                 vb_ff, okb_ff, swb_ff, use0b_ff, use1b_ff, sdbb_ff, sn2b_ff;
   logic [EW-1:0]        mdbb_ff, mn1b_ff, mn2b_ff, dab_ff;
   logic signed [EW-1:0] fa0b_ff, fa1b_ff, fb0b_ff, fb1b_ff;
   logic [SIDE_W-1:0]    sideb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         okb_ff   <= oka_ff && (verta_ff ? okv : oknv);
         swb_ff   <= swa_ff;
         use0b_ff <= !verta_ff && c0;
         use1b_ff <= !verta_ff && c1;
         sdbb_ff  <= db[EW-1];
         sn2b_ff  <= na2[EW-1];
         mdbb_ff  <= db[EW-1] ? $unsigned(-db) : $unsigned(db);
         mn1b_ff  <= $unsigned(na1);
         mn2b_ff  <= na2[EW-1] ? $unsigned(-na2) : $unsigned(na2);
         dab_ff   <= $unsigned(da);
         fa0b_ff  <= verta_ff ? a0a_ff : a0c;
         fa1b_ff  <= verta_ff ? a1a_ff : a1c;
         fb0b_ff  <= verta_ff ? b0c : b0a_ff;
         fb1b_ff  <= verta_ff ? b1c : b1a_ff;
         sideb_ff <= sidea_ff;
      end
   end

   // multiply stage
   logic              vc_ff;
   logic [NW-1:0]     p1c_ff, p2c_ff;
   logic [EW-1:0]     dac_ff;
   logic              s2c_ff;
   logic [CTX_W-1:0]  ctxc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1c_ff  <= mdbb_ff * mn1b_ff;
         p2c_ff  <= mdbb_ff * mn2b_ff;
         dac_ff  <= dab_ff;
         s2c_ff  <= sdbb_ff ^ sn2b_ff;
         ctxc_ff <= {okb_ff, swb_ff, use0b_ff, use1b_ff, sdbb_ff,
                     fa0b_ff, fa1b_ff, fb0b_ff, fb1b_ff, sideb_ff};
      end
   end

   // near and far quotients
   logic             vd1, vd2;
   logic [EW-1:0]    q1, q2;
   logic [CTX_W-1:0] ctxd;
   logic             s2d;

   lcw_div #(.DW(EW), .QW(EW), .SW(CTX_W)) u_div_near (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc_ff),
      .in_num    (p1c_ff),
      .in_den    (dac_ff),
      .in_side   (ctxc_ff),
      .out_valid (vd1),
      .out_quo   (q1),
      .out_side  (ctxd)
   );

   lcw_div #(.DW(EW), .QW(EW), .SW(1)) u_div_far (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vc_ff),
      .in_num    (p2c_ff),
      .in_den    (dac_ff),
      .in_side   (s2c_ff),
      .out_valid (vd2),
      .out_quo   (q2),
      .out_side  (s2d)
   );

   // apply quotients
   logic                 okd, swd, use0d, use1d, s1d;
   logic signed [EW-1:0] fa0d, fa1d, fb0d, fb1d;
   logic [SIDE_W-1:0]    sided;
   logic signed [EW:0]   q1s, q2s;
   logic signed [EW-1:0] b0n, b1n;

   assign {okd, swd, use0d, use1d, s1d, fa0d, fa1d, fb0d, fb1d, sided} = ctxd;
   assign q1s = s1d ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
   assign q2s = s2d ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
   assign b0n = use0d ? EW'(fb0d + q1s[EW-1:0]) : fb0d;
   assign b1n = use1d ? EW'(b0n + q2s[EW-1:0]) : fb1d;

   logic                 vo_ff, oko_ff, swo_ff;
   logic signed [EW-1:0] a0o_ff, b0o_ff, a1o_ff, b1o_ff;
   logic [SIDE_W-1:0]    sideo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vd1 && vd2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         oko_ff   <= okd;
         swo_ff   <= swd;
         a0o_ff   <= fa0d;
         a1o_ff   <= fa1d;
         b0o_ff   <= b0n;
         b1o_ff   <= b1n;
         sideo_ff <= sided;
      end
   end

   assign out_flags.valid = vo_ff;
   assign out_flags.ok    = oko_ff;
   assign out_flags.swap  = swo_ff;
   assign out_a0   = a0o_ff;
   assign out_b0   = b0o_ff;
   assign out_a1   = a1o_ff;
   assign out_b1   = b1o_ff;
   assign out_side = sideo_ff;

endmodule
